[hdl/lavm_pkg.sv]
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared widths, stage map and fixed-point helpers for the look-at view
// matrix pipeline.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int CW     = 52;   // signed vector component into the unit pipeline
  localparam int MW     = 52;   // component magnitude
  localparam int PW     = 6;    // leading-one position
  localparam int SW     = 30;   // scaled magnitude, top bit at SW-1
  localparam int SQW    = 60;   // square of a scaled magnitude
  localparam int SUMW   = 62;   // sum of three squares
  localparam int RW     = 64;   // root working word
  localparam int LW     = 31;   // vector length
  localparam int NW     = 47;   // division numerator and remainder
  localparam int QW     = 17;   // quotient
  localparam int UW     = 18;   // unit component, signed Q1.16
  localparam int SIDE_W = 192;  // word carried alongside the unit pipeline

  localparam int SQ_N   = 31;
  localparam int DV_N   = 17;
  localparam int US_SQ0 = 5;
  localparam int US_DV0 = US_SQ0 + SQ_N;
  localparam int US_N   = US_DV0 + DV_N + 1;

  localparam logic [LW-1:0] LEN_MIN = LW'(1) << (SW - 1);

  typedef struct packed {
    logic [2:0]             neg;
    logic                   zero;
    logic [2:0][SW-1:0]     mag;
  } ucar_t;

  function automatic logic [PW-1:0] msb_pos(input logic [MW-1:0] x);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < MW; i++) begin
      if (x[i]) p = PW'(i);
    end
    return p;
  endfunction

  function automatic logic signed [31:0] rnd_sat32(input logic signed [51:0] x);
    logic signed [52:0] v;
    logic signed [36:0] t;
    v = 53'(x) + 53'sd32768;
    t = 37'(v >>> 16);
    if (t > 37'sd2147483647) return 32'sh7fffffff;
    if (t < -37'sd2147483648) return 32'sh80000000;
    return 32'(t);
  endfunction

  function automatic logic signed [UW-1:0] rnd_unit(input logic signed [36:0] x);
    logic signed [37:0] v;
    logic signed [21:0] t;
    v = 38'(x) + 38'sd32768;
    t = 22'(v >>> 16);
    if (t > 22'sd65536) return 18'sd65536;
    if (t < -22'sd65536) return -18'sd65536;
    return UW'(t);
  endfunction

endpackage

[hdl/look_at_view_matrix_core.sv]
// ----------------------------------------------------------------------------
// look_at_view_matrix_core
// Right-handed look-at view matrix: unit right, up and back (negated forward)
// rows in signed Q1.16 plus the three saturated translation terms in Q16.16.
// Throughput: one word per cycle while out_ready is high; every stage holds
// its own valid bit. Pipeline length is set by the two scaling pipelines
// (54 stages each: root and quotient resolved one bit per stage).
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_eye_x,
  input  logic signed [31:0] in_eye_y,
  input  logic signed [31:0] in_eye_z,
  input  logic signed [31:0] in_aim_x,
  input  logic signed [31:0] in_aim_y,
  input  logic signed [31:0] in_aim_z,
  input  logic signed [31:0] in_hint_x,
  input  logic signed [31:0] in_hint_y,
  input  logic signed [31:0] in_hint_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_right_x,
  output logic signed [17:0] out_right_y,
  output logic signed [17:0] out_right_z,
  output logic signed [17:0] out_upward_x,
  output logic signed [17:0] out_upward_y,
  output logic signed [17:0] out_upward_z,
  output logic signed [17:0] out_back_x,
  output logic signed [17:0] out_back_y,
  output logic signed [17:0] out_back_z,
  output logic signed [31:0] out_shift_x,
  output logic signed [31:0] out_shift_y,
  output logic signed [31:0] out_shift_z
);

  logic en_a, en_b, en_c, en_d, en_e, en_g, en_h;
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, g_vld_r, h_vld_r;

  logic signed [31:0] a_eye_r [3];
  logic signed [31:0] a_hint_r [3];
  logic signed [32:0] a_d_r [3];
  logic signed [32:0] a_d_nxt [3];

  logic                               u1_in_ready, u1_out_valid;
  logic signed [lavm_pkg::CW-1:0]     u1_c [3];
  logic        [lavm_pkg::SIDE_W-1:0] u1_side_in, u1_side_out;
  logic signed [lavm_pkg::UW-1:0]     u1_o [3];

  logic signed [31:0] b_eye_nxt [3];
  logic signed [31:0] b_hint_nxt [3];
  logic signed [49:0] b_p_nxt [6];
  logic signed [49:0] b_p_r [6];
  logic signed [31:0] b_eye_r [3];
  logic signed [17:0] b_f_r [3];

  logic signed [50:0] c_rr_r [3];
  logic signed [31:0] c_eye_r [3];
  logic signed [17:0] c_f_r [3];

  logic                               u2_in_ready, u2_out_valid;
  logic signed [lavm_pkg::CW-1:0]     u2_c [3];
  logic        [lavm_pkg::SIDE_W-1:0] u2_side_in, u2_side_out;
  logic signed [lavm_pkg::UW-1:0]     u2_o [3];

  logic signed [31:0] d_eye_nxt [3];
  logic signed [17:0] d_f_nxt [3];
  logic signed [35:0] d_prf_r [6];
  logic signed [49:0] d_pre_r [3];
  logic signed [49:0] d_pfe_r [3];
  logic signed [17:0] d_r_r [3];
  logic signed [17:0] d_f_r [3];
  logic signed [31:0] d_eye_r [3];

  logic signed [17:0] e_u_r [3];
  logic signed [51:0] e_dr_r, e_df_r;
  logic signed [17:0] e_r_r [3];
  logic signed [17:0] e_f_r [3];
  logic signed [31:0] e_eye_r [3];

  logic signed [49:0] g_pue_r [3];
  logic signed [31:0] g_tx_r, g_tz_r;
  logic signed [17:0] g_r_r [3];
  logic signed [17:0] g_f_r [3];
  logic signed [17:0] g_u_r [3];

  logic signed [17:0] h_r_r [3];
  logic signed [17:0] h_u_r [3];
  logic signed [17:0] h_b_r [3];
  logic signed [31:0] h_tx_r, h_ty_r, h_tz_r;
  logic signed [51:0] h_du_nxt;

  assign en_h = !h_vld_r || out_ready;
  assign en_g = !g_vld_r || en_h;
  assign en_e = !e_vld_r || en_g;
  assign en_d = !d_vld_r || en_e;
  assign en_c = !c_vld_r || u2_in_ready;
  assign en_b = !b_vld_r || en_c;
  assign en_a = !a_vld_r || u1_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
    end else begin
      if (en_a) a_vld_r <= in_valid;
      if (en_b) b_vld_r <= u1_out_valid;
      if (en_c) c_vld_r <= b_vld_r;
      if (en_d) d_vld_r <= u2_out_valid;
      if (en_e) e_vld_r <= d_vld_r;
      if (en_g) g_vld_r <= e_vld_r;
      if (en_h) h_vld_r <= g_vld_r;
    end
  end

  // forward direction, aim minus eye
  assign a_d_nxt[0] = 33'(in_aim_x) - 33'(in_eye_x);
  assign a_d_nxt[1] = 33'(in_aim_y) - 33'(in_eye_y);
  assign a_d_nxt[2] = 33'(in_aim_z) - 33'(in_eye_z);

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_eye_r  <= '{in_eye_x, in_eye_y, in_eye_z};
      a_hint_r <= '{in_hint_x, in_hint_y, in_hint_z};
      a_d_r    <= a_d_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) u1_c[i] = lavm_pkg::CW'(a_d_r[i]);
  end
  assign u1_side_in = {a_eye_r[0], a_eye_r[1], a_eye_r[2],
                       a_hint_r[0], a_hint_r[1], a_hint_r[2]};

  lavm_unit u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_vld_r),
    .in_ready  (u1_in_ready),
    .in_c      (u1_c),
    .in_side   (u1_side_in),
    .out_valid (u1_out_valid),
    .out_ready (en_b),
    .out_o     (u1_o),
    .out_side  (u1_side_out)
  );

  // forward cross hint
  assign b_eye_nxt  = '{u1_side_out[191:160], u1_side_out[159:128], u1_side_out[127:96]};
  assign b_hint_nxt = '{u1_side_out[95:64], u1_side_out[63:32], u1_side_out[31:0]};

  always_comb begin
    b_p_nxt[0] = u1_o[1] * b_hint_nxt[2];
    b_p_nxt[1] = u1_o[2] * b_hint_nxt[1];
    b_p_nxt[2] = u1_o[2] * b_hint_nxt[0];
    b_p_nxt[3] = u1_o[0] * b_hint_nxt[2];
    b_p_nxt[4] = u1_o[0] * b_hint_nxt[1];
    b_p_nxt[5] = u1_o[1] * b_hint_nxt[0];
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_p_r   <= b_p_nxt;
      b_eye_r <= b_eye_nxt;
      b_f_r   <= u1_o;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_rr_r[0] <= 51'(b_p_r[0]) - 51'(b_p_r[1]);
      c_rr_r[1] <= 51'(b_p_r[2]) - 51'(b_p_r[3]);
      c_rr_r[2] <= 51'(b_p_r[4]) - 51'(b_p_r[5]);
      c_eye_r   <= b_eye_r;
      c_f_r     <= b_f_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) u2_c[i] = lavm_pkg::CW'(c_rr_r[i]);
  end
  assign u2_side_in = {c_eye_r[0], c_eye_r[1], c_eye_r[2],
                       c_f_r[0], c_f_r[1], c_f_r[2], 42'd0};

  lavm_unit u_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_vld_r),
    .in_ready  (u2_in_ready),
    .in_c      (u2_c),
    .in_side   (u2_side_in),
    .out_valid (u2_out_valid),
    .out_ready (en_d),
    .out_o     (u2_o),
    .out_side  (u2_side_out)
  );

  assign d_eye_nxt = '{u2_side_out[191:160], u2_side_out[159:128], u2_side_out[127:96]};
  assign d_f_nxt   = '{u2_side_out[95:78], u2_side_out[77:60], u2_side_out[59:42]};

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_prf_r[0] <= 36'(u2_o[1]) * 36'(d_f_nxt[2]);
      d_prf_r[1] <= 36'(u2_o[2]) * 36'(d_f_nxt[1]);
      d_prf_r[2] <= 36'(u2_o[2]) * 36'(d_f_nxt[0]);
      d_prf_r[3] <= 36'(u2_o[0]) * 36'(d_f_nxt[2]);
      d_prf_r[4] <= 36'(u2_o[0]) * 36'(d_f_nxt[1]);
      d_prf_r[5] <= 36'(u2_o[1]) * 36'(d_f_nxt[0]);
      for (int i = 0; i < 3; i++) begin
        d_pre_r[i] <= 50'(u2_o[i]) * 50'(d_eye_nxt[i]);
        d_pfe_r[i] <= 50'(d_f_nxt[i]) * 50'(d_eye_nxt[i]);
      end
      d_r_r   <= u2_o;
      d_f_r   <= d_f_nxt;
      d_eye_r <= d_eye_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_u_r[0] <= lavm_pkg::rnd_unit(37'(d_prf_r[0]) - 37'(d_prf_r[1]));
      e_u_r[1] <= lavm_pkg::rnd_unit(37'(d_prf_r[2]) - 37'(d_prf_r[3]));
      e_u_r[2] <= lavm_pkg::rnd_unit(37'(d_prf_r[4]) - 37'(d_prf_r[5]));
      e_dr_r   <= 52'(d_pre_r[0]) + 52'(d_pre_r[1]) + 52'(d_pre_r[2]);
      e_df_r   <= 52'(d_pfe_r[0]) + 52'(d_pfe_r[1]) + 52'(d_pfe_r[2]);
      e_r_r    <= d_r_r;
      e_f_r    <= d_f_r;
      e_eye_r  <= d_eye_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_g) begin
      for (int i = 0; i < 3; i++) g_pue_r[i] <= 50'(e_u_r[i]) * 50'(e_eye_r[i]);
      g_tx_r <= lavm_pkg::rnd_sat32(-e_dr_r);
      g_tz_r <= lavm_pkg::rnd_sat32(e_df_r);
      g_r_r  <= e_r_r;
      g_f_r  <= e_f_r;
      g_u_r  <= e_u_r;
    end
  end

  assign h_du_nxt = 52'(g_pue_r[0]) + 52'(g_pue_r[1]) + 52'(g_pue_r[2]);

  always_ff @(posedge clk) begin
    if (en_h) begin
      h_r_r  <= g_r_r;
      h_u_r  <= g_u_r;
      for (int i = 0; i < 3; i++) h_b_r[i] <= -g_f_r[i];
      h_tx_r <= g_tx_r;
      h_ty_r <= lavm_pkg::rnd_sat32(-h_du_nxt);
      h_tz_r <= g_tz_r;
    end
  end

  assign in_ready     = en_a;
  assign out_valid    = h_vld_r;
  assign out_right_x  = h_r_r[0];
  assign out_right_y  = h_r_r[1];
  assign out_right_z  = h_r_r[2];
  assign out_upward_x = h_u_r[0];
  assign out_upward_y = h_u_r[1];
  assign out_upward_z = h_u_r[2];
  assign out_back_x   = h_b_r[0];
  assign out_back_y   = h_b_r[1];
  assign out_back_z   = h_b_r[2];
  assign out_shift_x  = h_tx_r;
  assign out_shift_y  = h_ty_r;
  assign out_shift_z  = h_tz_r;

  a_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    h_vld_r && h_b_r[0] == '0 && h_b_r[1] == '0 && h_b_r[2] == '0 |->
      h_r_r[0] == '0 && h_r_r[1] == '0 && h_r_r[2] == '0 &&
      h_u_r[0] == '0 && h_u_r[1] == '0 && h_u_r[2] == '0 &&
      h_tx_r == '0 && h_ty_r == '0 && h_tz_r == '0)
    else $error("zero forward gave nonzero word");

  a_zero_right: assert property (@(posedge clk) disable iff (!rst_n)
    h_vld_r && h_r_r[0] == '0 && h_r_r[1] == '0 && h_r_r[2] == '0 |->
      h_u_r[0] == '0 && h_u_r[1] == '0 && h_u_r[2] == '0 &&
      h_tx_r == '0 && h_ty_r == '0)
    else $error("zero right gave nonzero up or shift");

  a_up_range: assert property (@(posedge clk) disable iff (!rst_n)
    e_vld_r |->
      (e_u_r[0] <= 18'sd65536) && (e_u_r[0] >= -18'sd65536) &&
      (e_u_r[1] <= 18'sd65536) && (e_u_r[1] >= -18'sd65536) &&
      (e_u_r[2] <= 18'sd65536) && (e_u_r[2] >= -18'sd65536))
    else $error("up component out of range");

endmodule

[hdl/lavm_unit.sv]
// ----------------------------------------------------------------------------
// lavm_unit
// Pipelined vector scaling to unit length: block normalize, sum of squares,
// one root bit per stage, one quotient bit per stage, sign restore.
// ----------------------------------------------------------------------------
module lavm_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [lavm_pkg::CW-1:0]         in_c [3],
  input  logic        [lavm_pkg::SIDE_W-1:0]     in_side,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [lavm_pkg::UW-1:0]         out_o [3],
  output logic        [lavm_pkg::SIDE_W-1:0]     out_side
);

  logic [lavm_pkg::US_N-1:0]   vld_r;
  logic [lavm_pkg::US_N-1:0]   vld_nxt;
  logic [lavm_pkg::US_N-1:0]   en;
  logic [lavm_pkg::SIDE_W-1:0] side_r [lavm_pkg::US_N];

  logic [lavm_pkg::MW-1:0]     m0_r [3];
  logic [lavm_pkg::MW-1:0]     m0_nxt [3];
  logic [2:0]                  n0_r;
  logic [lavm_pkg::MW-1:0]     orv_r;
  logic [lavm_pkg::MW-1:0]     m1_r [3];
  logic [2:0]                  n1_r;
  logic [lavm_pkg::PW-1:0]     p1_r;
  logic                        z1_r;
  lavm_pkg::ucar_t             ca_r [2:lavm_pkg::US_N-2];
  lavm_pkg::ucar_t             ca2_nxt;
  logic [lavm_pkg::SQW-1:0]    sq_r [3];
  logic [lavm_pkg::SUMW-1:0]   sum_r;
  logic [lavm_pkg::RW-1:0]     sv_r [lavm_pkg::SQ_N];
  logic [lavm_pkg::RW-1:0]     sr_r [lavm_pkg::SQ_N];
  logic [lavm_pkg::NW-1:0]     rem_r [lavm_pkg::DV_N][3];
  logic [lavm_pkg::QW-1:0]     q_r [lavm_pkg::DV_N][3];
  logic [lavm_pkg::LW-1:0]     l_r [lavm_pkg::DV_N];
  logic signed [lavm_pkg::UW-1:0] o_r [3];
  logic signed [lavm_pkg::UW-1:0] o_nxt [3];

  assign en[lavm_pkg::US_N-1] = !vld_r[lavm_pkg::US_N-1] || out_ready;
  for (genvar k = 0; k < lavm_pkg::US_N - 1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  assign vld_nxt[0] = en[0] ? in_valid : vld_r[0];
  for (genvar k = 1; k < lavm_pkg::US_N; k++) begin : g_vld
    assign vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) side_r[0] <= in_side;
  end
  for (genvar k = 1; k < lavm_pkg::US_N; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) side_r[k] <= side_r[k-1];
    end
  end

  // magnitudes and their OR
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m0_nxt[i] = in_c[i][lavm_pkg::CW-1] ? lavm_pkg::MW'(-in_c[i])
                                           : lavm_pkg::MW'(in_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m0_r  <= m0_nxt;
      n0_r  <= {in_c[2][lavm_pkg::CW-1], in_c[1][lavm_pkg::CW-1],
                in_c[0][lavm_pkg::CW-1]};
      orv_r <= m0_nxt[0] | m0_nxt[1] | m0_nxt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m1_r <= m0_r;
      n1_r <= n0_r;
      p1_r <= lavm_pkg::msb_pos(orv_r);
      z1_r <= (orv_r == '0);
    end
  end

  // bring the largest magnitude into [2^29, 2^30)
  always_comb begin
    logic [lavm_pkg::MW-1:0] t;
    ca2_nxt.neg  = n1_r;
    ca2_nxt.zero = z1_r;
    for (int i = 0; i < 3; i++) begin
      if (p1_r >= lavm_pkg::PW'(lavm_pkg::SW - 1)) begin
        t = m1_r[i] >> (p1_r - lavm_pkg::PW'(lavm_pkg::SW - 1));
      end else begin
        t = m1_r[i] << (lavm_pkg::PW'(lavm_pkg::SW - 1) - p1_r);
      end
      ca2_nxt.mag[i] = t[lavm_pkg::SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) ca_r[2] <= ca2_nxt;
  end
  for (genvar k = 3; k < lavm_pkg::US_N - 1; k++) begin : g_car
    always_ff @(posedge clk) begin
      if (en[k]) ca_r[k] <= ca_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= lavm_pkg::SQW'(ca_r[2].mag[i]) * lavm_pkg::SQW'(ca_r[2].mag[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) sum_r <= lavm_pkg::SUMW'(sq_r[0]) + lavm_pkg::SUMW'(sq_r[1])
                        + lavm_pkg::SUMW'(sq_r[2]);
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < lavm_pkg::SQ_N; j++) begin : g_sq
    logic [lavm_pkg::RW-1:0] v_in;
    logic [lavm_pkg::RW-1:0] r_in;
    logic [lavm_pkg::RW-1:0] bit_v;
    logic [lavm_pkg::RW-1:0] t;
    logic [lavm_pkg::RW-1:0] v_nxt;
    logic [lavm_pkg::RW-1:0] r_nxt;
    if (j == 0) begin : g_first
      assign v_in = lavm_pkg::RW'(sum_r);
      assign r_in = '0;
    end else begin : g_rest
      assign v_in = sv_r[j-1];
      assign r_in = sr_r[j-1];
    end
    assign bit_v = lavm_pkg::RW'(1) << (2 * (lavm_pkg::SQ_N - 1 - j));
    assign t     = r_in + bit_v;
    always_comb begin
      if (v_in >= t) begin
        v_nxt = v_in - t;
        r_nxt = (r_in >> 1) + bit_v;
      end else begin
        v_nxt = v_in;
        r_nxt = r_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en[lavm_pkg::US_SQ0+j]) begin
        sv_r[j] <= v_nxt;
        sr_r[j] <= r_nxt;
      end
    end
  end

  // rounded quotient (mag * 2^16 + len/2) / len, one bit per stage
  for (genvar j = 0; j < lavm_pkg::DV_N; j++) begin : g_dv
    logic [lavm_pkg::LW-1:0] l_in;
    logic [lavm_pkg::NW-1:0] r_in [3];
    logic [lavm_pkg::QW-1:0] q_in [3];
    logic [lavm_pkg::NW-1:0] r_nxt [3];
    logic [lavm_pkg::QW-1:0] q_nxt [3];
    logic [lavm_pkg::NW-1:0] dsr;
    if (j == 0) begin : g_first
      assign l_in = sr_r[lavm_pkg::SQ_N-1][lavm_pkg::LW-1:0];
      for (genvar i = 0; i < 3; i++) begin : g_num
        assign r_in[i] = (lavm_pkg::NW'(ca_r[lavm_pkg::US_DV0-1].mag[i]) << 16)
                         + lavm_pkg::NW'(l_in >> 1);
        assign q_in[i] = '0;
      end
    end else begin : g_rest
      assign l_in = l_r[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_cp
        assign r_in[i] = rem_r[j-1][i];
        assign q_in[i] = q_r[j-1][i];
      end
    end
    assign dsr = lavm_pkg::NW'(l_in) << (lavm_pkg::DV_N - 1 - j);
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (r_in[i] >= dsr) begin
          r_nxt[i] = r_in[i] - dsr;
          q_nxt[i] = q_in[i] | (lavm_pkg::QW'(1) << (lavm_pkg::DV_N - 1 - j));
        end else begin
          r_nxt[i] = r_in[i];
          q_nxt[i] = q_in[i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[lavm_pkg::US_DV0+j]) begin
        l_r[j]   <= l_in;
        rem_r[j] <= r_nxt;
        q_r[j]   <= q_nxt;
      end
    end
  end

  // restore sign, force zero vectors to zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ca_r[lavm_pkg::US_N-2].zero) begin
        o_nxt[i] = '0;
      end else if (ca_r[lavm_pkg::US_N-2].neg[i]) begin
        o_nxt[i] = -lavm_pkg::UW'(q_r[lavm_pkg::DV_N-1][i]);
      end else begin
        o_nxt[i] = lavm_pkg::UW'(q_r[lavm_pkg::DV_N-1][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[lavm_pkg::US_N-1]) o_r <= o_nxt;
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[lavm_pkg::US_N-1];
  assign out_o     = o_r;
  assign out_side  = side_r[lavm_pkg::US_N-1];

  a_scaled_top: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] && !ca_r[2].zero |->
      (ca_r[2].mag[0][lavm_pkg::SW-1] || ca_r[2].mag[1][lavm_pkg::SW-1] ||
       ca_r[2].mag[2][lavm_pkg::SW-1]))
    else $error("scaled magnitude not normalized");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[lavm_pkg::US_DV0-1] && !ca_r[lavm_pkg::US_DV0-1].zero |->
      (sr_r[lavm_pkg::SQ_N-1] >= lavm_pkg::RW'(lavm_pkg::LEN_MIN)) &&
      (sr_r[lavm_pkg::SQ_N-1] < (lavm_pkg::RW'(1) << lavm_pkg::LW)))
    else $error("vector length out of range");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (o_r[0] <= 18'sd65536) && (o_r[0] >= -18'sd65536) &&
      (o_r[1] <= 18'sd65536) && (o_r[1] >= -18'sd65536) &&
      (o_r[2] <= 18'sd65536) && (o_r[2] >= -18'sd65536))
    else $error("unit component out of range");

endmodule
